FILE: rtl/gmbm_pkg.sv
// Shared types and constants of the Gaussian mixture background model.
// Holds the word formats, the configuration record and the unit request types.
// No dependencies.
package gmbm_pkg;

    localparam int PIXELS_DEF        = 131072;
    localparam int COMPONENTS_DEF    = 3;
    localparam int WARMUP_FRAMES_DEF = 10;

    localparam int IDX_W     = 17;
    localparam int PIX_W     = 8;
    localparam int FRAME_W   = 16;
    localparam int MEAN_W    = 16;
    localparam int VAR_W     = 24;
    localparam int WGT_W     = 17;
    localparam int COMP_W    = MEAN_W + VAR_W + WGT_W;
    localparam int RATE_W    = 16;
    localparam int SIGMA_W   = 12;
    localparam int WSUM_W    = 12;
    localparam int WSQ_W     = 20;
    localparam int SUM_W     = 20;

    localparam int MAC_OW    = 25;
    localparam int MAC_PW    = 50;

    localparam int DIV_RW    = 20;
    localparam int DIV_LW    = 28;
    localparam int DIV_CW    = 5;

    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam logic [WGT_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [WGT_W-1:0] NEW_WEIGHT = 17'd3277;
    localparam logic [VAR_W-1:0] VAR_MAX    = 24'hFFFFFF;

    localparam logic [2:0] REG_UNIMODAL  = 3'd0;
    localparam logic [2:0] REG_RATE      = 3'd1;
    localparam logic [2:0] REG_SIGMA     = 3'd2;
    localparam logic [2:0] REG_START_VAR = 3'd3;
    localparam logic [2:0] REG_MARGIN    = 3'd4;
    localparam logic [2:0] REG_SELECTIVE = 3'd5;

    typedef struct packed {
        logic [IDX_W-1:0]   pixel_index;
        logic [PIX_W-1:0]   pixel_value;
        logic [FRAME_W-1:0] frame_number;
    } pixel_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] pixel_index_out;
        logic             foreground;
    } pixel_out_t;

    typedef struct packed {
        logic               unimodal_mode;
        logic [RATE_W-1:0]  learn_rate;
        logic [SIGMA_W-1:0] sigma_multiple;
        logic [VAR_W-1:0]   start_variance;
        logic [RATE_W-1:0]  weight_margin;
        logic               selective_update;
    } cfg_t;

    typedef struct packed {
        logic [MAC_OW-1:0] a;
        logic [MAC_OW-1:0] b;
        logic [MAC_PW-1:0] c;
    } mac_req_t;

    typedef struct packed {
        logic              start;
        logic [DIV_RW-1:0] rem_init;
        logic [DIV_LW-1:0] low_init;
        logic [DIV_CW-1:0] nbits;
        logic [DIV_RW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_LW-1:0] quot;
        logic [DIV_RW-1:0] rem;
    } div_rsp_t;

endpackage

FILE: rtl/gmbm_mac.sv
// Shared multiply-add unit: one product plus an addend, registered.
// Depends on gmbm_pkg.
module gmbm_mac (
    input  logic                       clk,
    input  gmbm_pkg::mac_req_t         req,
    output logic [gmbm_pkg::MAC_PW-1:0] prod
);
    import gmbm_pkg::*;

    logic [MAC_PW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MAC_PW'(req.a) * MAC_PW'(req.b) + req.c;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/gmbm_div.sv
// Restoring divider that settles one quotient bit per cycle.
// The caller preloads the upper remainder and the low dividend bits.
// Depends on gmbm_pkg.
module gmbm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  gmbm_pkg::div_req_t req,
    output gmbm_pkg::div_rsp_t rsp
);
    import gmbm_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_RW-1:0] rem_reg, rem_next;
    logic [DIV_LW-1:0] low_reg, low_next;
    logic [DIV_LW-1:0] quot_reg, quot_next;
    logic [DIV_RW-1:0] divisor_reg, divisor_next;
    logic [DIV_RW:0]   trial;
    logic [DIV_RW:0]   diff;
    logic              fits;

    always_comb
    begin
        trial        = {rem_reg, low_reg[DIV_LW-1]};
        diff         = trial - {1'b0, divisor_reg};
        fits         = trial >= {1'b0, divisor_reg};
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        low_next     = low_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = req.nbits;
            rem_next     = req.rem_init;
            low_next     = req.low_init;
            quot_next    = '0;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
            low_next  = {low_reg[DIV_LW-2:0], 1'b0};
            quot_next = {quot_reg[DIV_LW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        low_reg     <= low_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: rtl/gmbm_cfg.sv
// Configuration register file behind an APB-style port.
// Depends on gmbm_pkg.
module gmbm_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gmbm_pkg::PADDR_W-1:0] paddr,
    input  logic [gmbm_pkg::PDATA_W-1:0] pwdata,
    output logic [gmbm_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output gmbm_pkg::cfg_t               cfg
);
    import gmbm_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic [2:0] sel;

    assign sel = paddr[PADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (sel)
                REG_UNIMODAL:  cfg_next.unimodal_mode    = pwdata[0];
                REG_RATE:      cfg_next.learn_rate       = pwdata[RATE_W-1:0];
                REG_SIGMA:     cfg_next.sigma_multiple   = pwdata[SIGMA_W-1:0];
                REG_START_VAR: cfg_next.start_variance   = pwdata[VAR_W-1:0];
                REG_MARGIN:    cfg_next.weight_margin    = pwdata[RATE_W-1:0];
                REG_SELECTIVE: cfg_next.selective_update = pwdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_UNIMODAL:  prdata = PDATA_W'(cfg_reg.unimodal_mode);
            REG_RATE:      prdata = PDATA_W'(cfg_reg.learn_rate);
            REG_SIGMA:     prdata = PDATA_W'(cfg_reg.sigma_multiple);
            REG_START_VAR: prdata = PDATA_W'(cfg_reg.start_variance);
            REG_MARGIN:    prdata = PDATA_W'(cfg_reg.weight_margin);
            REG_SELECTIVE: prdata = PDATA_W'(cfg_reg.selective_update);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unimodal_mode    <= 1'b0;
            cfg_reg.learn_rate       <= 16'd3277;
            cfg_reg.sigma_multiple   <= 12'd640;
            cfg_reg.start_variance   <= 24'd12800;
            cfg_reg.weight_margin    <= 16'd19661;
            cfg_reg.selective_update <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

FILE: rtl/gmbm_core.sv
// Sequencer, per-pixel model memories and working registers of the model.
// Drives the shared multiply-add unit and the shared divider.
// Depends on gmbm_pkg, gmbm_mac and gmbm_div.
module gmbm_core #(
    parameter int PIXELS        = gmbm_pkg::PIXELS_DEF,
    parameter int COMPONENTS    = gmbm_pkg::COMPONENTS_DEF,
    parameter int WARMUP_FRAMES = gmbm_pkg::WARMUP_FRAMES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gmbm_pkg::cfg_t       cfg,
    input  logic                 pixel_valid,
    output logic                 pixel_ready,
    input  gmbm_pkg::pixel_in_t  pixel,
    output logic                 result_valid,
    input  logic                 result_ready,
    output gmbm_pkg::pixel_out_t result
);
    import gmbm_pkg::*;

    localparam int  AW    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int  KW    = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
    localparam int  ROW_W = COMPONENTS * COMP_W;
    localparam bit  WRAP  = (PIXELS < (1 << IDX_W));
    // Scaled reciprocal of PIXELS; the quotient estimate is low by at most one.
    localparam int  MOD_RECIP = (1 << 24) / PIXELS;

    typedef enum logic [27:0] {
        S_CLEAR  = 28'h0000001,
        S_IDLE   = 28'h0000002,
        S_MOD    = 28'h0000004,
        S_READ   = 28'h0000008,
        S_LOAD   = 28'h0000010,
        S_TEST1  = 28'h0000020,
        S_TEST2  = 28'h0000040,
        S_TEST3  = 28'h0000080,
        S_UPD1   = 28'h0000100,
        S_UPD2   = 28'h0000200,
        S_UPD3   = 28'h0000400,
        S_UPD4   = 28'h0000800,
        S_UPD5   = 28'h0001000,
        S_UPD6   = 28'h0002000,
        S_BLEND1 = 28'h0004000,
        S_BLEND2 = 28'h0008000,
        S_NDIV   = 28'h0010000,
        S_NWAIT  = 28'h0020000,
        S_DECIDE = 28'h0040000,
        S_SUM    = 28'h0080000,
        S_WARM0  = 28'h0100000,
        S_WARM1  = 28'h0200000,
        S_WARM2  = 28'h0400000,
        S_WARM3  = 28'h0800000,
        S_WB     = 28'h1000000,
        S_DONE   = 28'h2000000,
        S_MOD2   = 28'h4000000,
        S_MOD3   = 28'h8000000
    } state_t;

    state_t state_reg, state_next;

    logic [ROW_W-1:0]         comp_mem [PIXELS];
    logic [WSUM_W+WSQ_W-1:0]  warm_mem [PIXELS];
    logic [ROW_W-1:0]         comp_rdata_reg;
    logic [WSUM_W+WSQ_W-1:0]  warm_rdata_reg;
    logic                     rd_en, wr_en;
    logic [AW-1:0]            wr_addr;
    logic [ROW_W-1:0]         comp_wdata;
    logic [WSUM_W+WSQ_W-1:0]  warm_wdata;

    logic [AW-1:0]       clr_reg, clr_next;
    logic [KW-1:0]       k_reg, k_next;
    logic                out_valid_reg, out_valid_next;
    pixel_out_t          out_reg, out_next;

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    p_reg, p_next;
    logic [PIX_W-1:0]    x_reg, x_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [MEAN_W-1:0]   mean_reg [COMPONENTS];
    logic [MEAN_W-1:0]   mean_next [COMPONENTS];
    logic [VAR_W-1:0]    var_reg [COMPONENTS];
    logic [VAR_W-1:0]    var_next [COMPONENTS];
    logic [WGT_W-1:0]    w_reg [COMPONENTS];
    logic [WGT_W-1:0]    w_next [COMPONENTS];
    logic [COMPONENTS-1:0] hit_reg, hit_next;
    logic [31:0]         lhs_reg, lhs_next;
    logic [VAR_W-1:0]    s2_reg, s2_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                fg_reg, fg_next;
    logic                pass_reg, pass_next;
    logic [WSUM_W-1:0]   wsum_reg, wsum_next;
    logic [WSQ_W-1:0]    wsq_reg, wsq_next;

    mac_req_t            mac_req;
    logic [MAC_PW-1:0]   prod;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    logic [MEAN_W-1:0]   x88;
    logic [WGT_W-1:0]    na;
    logic [WGT_W-1:0]    thr;
    logic [AW-1:0]       addr;
    logic                fg_c;
    logic [KW-1:0]       min_arg;

    gmbm_mac u_mac (
        .clk  (clk),
        .req  (mac_req),
        .prod (prod)
    );

    gmbm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign x88  = {x_reg, 8'b0};
    assign na   = ONE_Q16 - WGT_W'(cfg.learn_rate);
    assign thr  = ONE_Q16 - WGT_W'(cfg.weight_margin);
    assign addr = AW'(p_reg);

    // Background when a matched component, scanned in order, is heavy
    // enough; otherwise remember the lightest component seen so far.
    always_comb
    begin
        logic             stop;
        logic [WGT_W-1:0] lightest;
        fg_c      = 1'b1;
        stop      = 1'b0;
        lightest  = ONE_Q16;
        min_arg   = '0;
        for (int i = 0; i < COMPONENTS; i++)
        begin
            if (!stop)
            begin
                if (hit_reg[i] && (w_reg[i] >= thr))
                begin
                    fg_c = 1'b0;
                    stop = 1'b1;
                end
                else if (w_reg[i] < lightest)
                begin
                    lightest = w_reg[i];
                    min_arg  = KW'(i);
                end
            end
        end
    end

    always_comb
    begin
        logic [MEAN_W-1:0]  d;
        logic [MEAN_W-1:0]  m;
        logic [33:0]        v;
        logic [WGT_W-1:0]   wn;
        logic [33:0]        dividend;
        logic [WSUM_W:0]    s13;
        logic [WSUM_W-1:0]  s;
        logic [WSQ_W-1:0]   q;
        logic [DIV_LW-1:0]  ex2;
        logic [VAR_W-1:0]   m2;
        logic [DIV_LW-1:0]  diff;
        logic [IDX_W-1:0]   wrapped;
        logic               last;

        d        = '0;
        m        = '0;
        v        = '0;
        wn       = '0;
        dividend = '0;
        s13      = '0;
        s        = '0;
        q        = '0;
        ex2      = '0;
        m2       = '0;
        diff     = '0;
        wrapped  = '0;
        last     = (k_reg == KW'(COMPONENTS - 1));

        state_next     = state_reg;
        clr_next       = clr_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        idx_next       = idx_reg;
        p_next         = p_reg;
        x_next         = x_reg;
        frame_next     = frame_reg;
        mean_next      = mean_reg;
        var_next       = var_reg;
        w_next         = w_reg;
        hit_next       = hit_reg;
        lhs_next       = lhs_reg;
        s2_next        = s2_reg;
        sum_next       = sum_reg;
        fg_next        = fg_reg;
        pass_next      = pass_reg;
        wsum_next      = wsum_reg;
        wsq_next       = wsq_reg;

        mac_req        = '0;
        div_req        = '0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = addr;
        comp_wdata     = '0;
        warm_wdata     = {wsum_reg, wsq_reg};
        for (int i = 0; i < COMPONENTS; i++)
        begin
            comp_wdata[i*COMP_W +: COMP_W] = {w_reg[i], var_reg[i], mean_reg[i]};
        end

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en      = 1'b1;
                wr_addr    = clr_reg;
                comp_wdata = '0;
                warm_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == AW'(PIXELS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (pixel_valid)
                begin
                    idx_next   = pixel.pixel_index;
                    p_next     = pixel.pixel_index;
                    x_next     = pixel.pixel_value;
                    frame_next = (pixel.frame_number == '0) ? FRAME_W'(1)
                                                            : pixel.frame_number;
                    state_next = WRAP ? S_MOD : S_READ;
                end
            end
            S_MOD:
            begin
                mac_req.a  = MAC_OW'(idx_reg);
                mac_req.b  = MAC_OW'(MOD_RECIP);
                state_next = S_MOD2;
            end
            S_MOD2:
            begin
                mac_req.a  = MAC_OW'(prod[24 +: IDX_W]);
                mac_req.b  = MAC_OW'(PIXELS);
                state_next = S_MOD3;
            end
            S_MOD3:
            begin
                wrapped = idx_reg - prod[IDX_W-1:0];
                if (wrapped >= IDX_W'(PIXELS))
                begin
                    wrapped = wrapped - IDX_W'(PIXELS);
                end
                p_next     = wrapped;
                state_next = S_READ;
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                mac_req.a  = MAC_OW'(cfg.sigma_multiple);
                mac_req.b  = MAC_OW'(cfg.sigma_multiple);
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                for (int i = 0; i < COMPONENTS; i++)
                begin
                    mean_next[i] = comp_rdata_reg[i*COMP_W +: MEAN_W];
                    var_next[i]  = comp_rdata_reg[i*COMP_W + MEAN_W +: VAR_W];
                    w_next[i]    = comp_rdata_reg[i*COMP_W + MEAN_W + VAR_W +: WGT_W];
                end
                wsum_next = warm_rdata_reg[WSUM_W+WSQ_W-1:WSQ_W];
                wsq_next  = warm_rdata_reg[WSQ_W-1:0];
                s2_next   = prod[VAR_W-1:0];
                k_next    = '0;
                sum_next  = '0;
                hit_next  = '0;
                fg_next   = 1'b0;
                pass_next = 1'b0;
                if (cfg.unimodal_mode)
                begin
                    state_next = (frame_reg <= FRAME_W'(WARMUP_FRAMES)) ? S_WARM0 : S_TEST1;
                end
                else
                begin
                    // First mixture frame seeds component 0 before the test.
                    if (frame_reg == FRAME_W'(1))
                    begin
                        mean_next[0] = x88;
                        var_next[0]  = cfg.start_variance;
                        w_next[0]    = ONE_Q16;
                    end
                    state_next = S_TEST1;
                end
            end
            S_TEST1:
            begin
                d = (x88 >= mean_reg[k_reg]) ? x88 - mean_reg[k_reg] : mean_reg[k_reg] - x88;
                mac_req.a  = MAC_OW'(d);
                mac_req.b  = MAC_OW'(d);
                state_next = S_TEST2;
            end
            S_TEST2:
            begin
                lhs_next   = prod[31:0];
                mac_req.a  = MAC_OW'(s2_reg);
                mac_req.b  = MAC_OW'(var_reg[k_reg]);
                state_next = S_TEST3;
            end
            S_TEST3:
            begin
                // Squared deviation in Q16.16 against sigma squared times variance.
                if ({8'b0, lhs_reg, 8'b0} <= prod[47:0])
                begin
                    hit_next[k_reg] = 1'b1;
                    state_next      = S_UPD1;
                end
                else if (cfg.unimodal_mode)
                begin
                    fg_next    = 1'b1;
                    state_next = S_WB;
                end
                else
                begin
                    state_next = S_BLEND1;
                end
            end
            S_UPD1:
            begin
                mac_req.a  = MAC_OW'(cfg.learn_rate);
                mac_req.b  = MAC_OW'(x88);
                mac_req.c  = MAC_PW'(32768);
                state_next = S_UPD2;
            end
            S_UPD2:
            begin
                mac_req.a  = MAC_OW'(na);
                mac_req.b  = MAC_OW'(mean_reg[k_reg]);
                mac_req.c  = prod;
                state_next = S_UPD3;
            end
            S_UPD3:
            begin
                m = prod[31:16];
                mean_next[k_reg] = m;
                d = (x88 >= m) ? x88 - m : m - x88;
                mac_req.a  = MAC_OW'(d);
                mac_req.b  = MAC_OW'(d);
                mac_req.c  = MAC_PW'(128);
                state_next = S_UPD4;
            end
            S_UPD4:
            begin
                mac_req.a  = MAC_OW'(cfg.learn_rate);
                mac_req.b  = MAC_OW'(prod[31:8]);
                mac_req.c  = MAC_PW'(32768);
                state_next = S_UPD5;
            end
            S_UPD5:
            begin
                mac_req.a  = MAC_OW'(na);
                mac_req.b  = MAC_OW'(var_reg[k_reg]);
                mac_req.c  = prod;
                state_next = S_UPD6;
            end
            S_UPD6:
            begin
                v = prod[49:16];
                var_next[k_reg] = (v > 34'(VAR_MAX)) ? VAR_MAX : v[VAR_W-1:0];
                state_next = cfg.unimodal_mode ? S_WB : S_BLEND1;
            end
            S_BLEND1:
            begin
                mac_req.a = MAC_OW'(na);
                mac_req.b = MAC_OW'(w_reg[k_reg]);
                mac_req.c = (hit_reg[k_reg] ? (MAC_PW'(cfg.learn_rate) << 16) : '0)
                            + MAC_PW'(32768);
                state_next = S_BLEND2;
            end
            S_BLEND2:
            begin
                wn = prod[32:16];
                w_next[k_reg] = wn;
                sum_next = sum_reg + SUM_W'(wn);
                if (last)
                begin
                    k_next     = '0;
                    state_next = (sum_next == '0) ? S_DECIDE : S_NDIV;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_TEST1;
                end
            end
            S_NDIV:
            begin
                // The quotient fits 17 bits, so the top of the dividend
                // preloads the remainder.
                dividend = {w_reg[k_reg], 16'b0} + 34'(sum_reg >> 1);
                div_req.start    = 1'b1;
                div_req.rem_init = DIV_RW'(dividend[33:17]);
                div_req.low_init = {dividend[16:0], 11'b0};
                div_req.nbits    = DIV_CW'(17);
                div_req.divisor  = sum_reg;
                state_next       = S_NWAIT;
            end
            S_NWAIT:
            begin
                if (div_rsp.done)
                begin
                    w_next[k_reg] = div_rsp.quot[WGT_W-1:0];
                    if (last)
                    begin
                        k_next     = '0;
                        state_next = pass_reg ? S_WB : S_DECIDE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_NDIV;
                    end
                end
            end
            S_DECIDE:
            begin
                fg_next = fg_c;
                if (fg_c && !cfg.selective_update && (hit_reg == '0))
                begin
                    w_next[min_arg]    = NEW_WEIGHT;
                    mean_next[min_arg] = x88;
                    var_next[min_arg]  = cfg.start_variance;
                    sum_next           = '0;
                    k_next             = '0;
                    pass_next          = 1'b1;
                    state_next         = S_SUM;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_SUM:
            begin
                sum_next = sum_reg + SUM_W'(w_reg[k_reg]);
                if (last)
                begin
                    k_next     = '0;
                    state_next = (sum_next == '0) ? S_WB : S_NDIV;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_WARM0:
            begin
                mac_req.a  = MAC_OW'(x_reg);
                mac_req.b  = MAC_OW'(x_reg);
                mac_req.c  = MAC_PW'(wsq_reg);
                state_next = S_WARM1;
            end
            S_WARM1:
            begin
                s13 = (WSUM_W+1)'(wsum_reg) + (WSUM_W+1)'(x_reg);
                s   = (s13 > (WSUM_W+1)'(12'hFFF)) ? 12'hFFF : s13[WSUM_W-1:0];
                q   = (prod > MAC_PW'(20'hFFFFF)) ? 20'hFFFFF : prod[WSQ_W-1:0];
                wsum_next        = s;
                wsq_next         = q;
                div_req.start    = 1'b1;
                div_req.low_init = (DIV_LW'(s) << 8) + DIV_LW'(frame_reg >> 1);
                div_req.nbits    = DIV_CW'(DIV_LW);
                div_req.divisor  = DIV_RW'(frame_reg);
                state_next       = S_WARM2;
            end
            S_WARM2:
            begin
                if (div_rsp.done)
                begin
                    mean_next[0] = (div_rsp.quot > DIV_LW'(16'hFFFF)) ? 16'hFFFF
                                                                     : div_rsp.quot[MEAN_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.low_init = (DIV_LW'(wsq_reg) << 8) + DIV_LW'(frame_reg >> 1);
                    div_req.nbits    = DIV_CW'(DIV_LW);
                    div_req.divisor  = DIV_RW'(frame_reg);
                    state_next       = S_WARM3;
                end
            end
            S_WARM3:
            begin
                mac_req.a = MAC_OW'(mean_reg[0]);
                mac_req.b = MAC_OW'(mean_reg[0]);
                if (div_rsp.done)
                begin
                    ex2  = div_rsp.quot;
                    m2   = prod[31:8];
                    diff = (ex2 > DIV_LW'(m2)) ? ex2 - DIV_LW'(m2) : '0;
                    var_next[0] = (diff > DIV_LW'(VAR_MAX)) ? VAR_MAX : diff[VAR_W-1:0];
                    state_next  = S_WB;
                end
            end
            S_WB:
            begin
                wr_en      = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_next.pixel_index_out = idx_reg;
                    out_next.foreground      = fg_reg;
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            comp_rdata_reg <= comp_mem[addr];
            warm_rdata_reg <= warm_mem[addr];
        end
        if (wr_en)
        begin
            comp_mem[wr_addr] <= comp_wdata;
            warm_mem[wr_addr] <= warm_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            pass_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            pass_reg      <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        idx_reg   <= idx_next;
        p_reg     <= p_next;
        x_reg     <= x_next;
        frame_reg <= frame_next;
        mean_reg  <= mean_next;
        var_reg   <= var_next;
        w_reg     <= w_next;
        hit_reg   <= hit_next;
        lhs_reg   <= lhs_next;
        s2_reg    <= s2_next;
        sum_reg   <= sum_next;
        fg_reg    <= fg_next;
        wsum_reg  <= wsum_next;
        wsq_reg   <= wsq_next;
    end

    assign pixel_ready  = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: rtl/gaussian_mixture_background_model.sv
// Gaussian background model for a stream of gray pixels: one foreground word per pixel word.
// After reset the block clears its per-pixel model memories, one pixel row per cycle, and
// takes no pixel meanwhile; register writes are taken at any time. Each pixel then runs on
// one shared multiply-add unit and one bit-serial divider under a sequencer, one pixel at a
// time. Mixture mode runs the component tests and updates (an unmatched component skips the
// update), then the weight normalization, and another weight sum and normalization when a
// component is replaced; unimodal mode skips the update for a foreground pixel, and the
// warmup frames run two 28-bit divides. When PIXELS is below 2^17 an index wrap, a
// reciprocal multiply and one correction, runs before the model read. A finished word waits
// in an output register while the next pixel is taken.
// Depends on gmbm_pkg, gmbm_cfg and gmbm_core.
module gaussian_mixture_background_model #(
    parameter int PIXELS        = gmbm_pkg::PIXELS_DEF,
    parameter int COMPONENTS    = gmbm_pkg::COMPONENTS_DEF,
    parameter int WARMUP_FRAMES = gmbm_pkg::WARMUP_FRAMES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gmbm_pkg::PADDR_W-1:0] paddr,
    input  logic [gmbm_pkg::PDATA_W-1:0] pwdata,
    output logic [gmbm_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         pixel_valid,
    output logic                         pixel_ready,
    input  gmbm_pkg::pixel_in_t          pixel,
    output logic                         result_valid,
    input  logic                         result_ready,
    output gmbm_pkg::pixel_out_t         result
);
    import gmbm_pkg::*;

    cfg_t cfg;

    gmbm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gmbm_core #(
        .PIXELS        (PIXELS),
        .COMPONENTS    (COMPONENTS),
        .WARMUP_FRAMES (WARMUP_FRAMES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: sim/tb_gaussian_mixture_background_model.sv
// Self-checking testbench for gaussian_mixture_background_model: pixel words with random
// scenes and register settings, a bit-accurate background-model predictor and a result checker.
// Depends on gmbm_pkg and the RTL of the block.
module tb_gaussian_mixture_background_model;
    import gmbm_pkg::*;

    localparam int NPIX       = PIXELS_DEF;
    localparam int NCOMP      = COMPONENTS_DEF;
    localparam int NWARM      = WARMUP_FRAMES_DEF;
    localparam int STALL_MAX  = 400000;
    localparam int HOLD_LEN   = 400;

    typedef bit [16:0] weight_vec_t [NCOMP];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic pixel_valid = 1'b0;
    logic pixel_ready;
    pixel_in_t pixel = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    pixel_out_t result;

    gaussian_mixture_background_model dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Model state kept by the predictor.
    bit [15:0] model_mean [NPIX*NCOMP];
    bit [23:0] model_var  [NPIX*NCOMP];
    bit [16:0] model_wgt  [NPIX*NCOMP];
    bit [11:0] model_sum  [NPIX];
    bit [19:0] model_sq   [NPIX];

    bit        cfg_unimodal  = 1'b0;
    bit [15:0] cfg_rate      = 16'd3277;
    bit [11:0] cfg_sigma     = 12'd640;
    bit [23:0] cfg_start_var = 24'd12800;
    bit [15:0] cfg_margin    = 16'd19661;
    bit        cfg_selective = 1'b0;

    pixel_in_t  pending_pixels [$];
    pixel_out_t expected_masks [$];
    int errors = 0;
    int results_seen = 0;
    int pixels_sent = 0;
    bit quiet_stretch = 1'b0;

    function automatic bit within_sigma(bit [15:0] x88, bit [15:0] mean, bit [23:0] var_q);
        longint unsigned d, lhs, rhs;
        d = (x88 > mean) ? x88 - mean : mean - x88;
        lhs = (d * d) << 8;
        rhs = longint'(cfg_sigma) * longint'(cfg_sigma) * longint'(var_q);
        return lhs <= rhs;
    endfunction

    task automatic blend_component(int at, bit [15:0] x88);
        longint unsigned a, na, m, d, d2, v;
        a = cfg_rate;
        na = 65536 - a;
        m = (a * x88 + na * model_mean[at] + 32768) >> 16;
        d = (x88 > m) ? x88 - m : m - x88;
        d2 = (d * d + 128) >> 8;
        v = (a * d2 + na * model_var[at] + 32768) >> 16;
        model_mean[at] = m[15:0];
        model_var[at] = (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
    endtask

    function automatic void normalize_weights(inout weight_vec_t w);
        longint unsigned total;
        total = 0;
        for (int k = 0; k < NCOMP; k++)
            total += w[k];
        if (total != 0)
            for (int k = 0; k < NCOMP; k++)
                w[k] = (longint'(w[k]) * 65536 + total / 2) / total;
    endfunction

    task automatic predict_mask(input pixel_in_t px, output pixel_out_t mask);
        int p, base;
        longint unsigned frame, s, q, mean, ex2, m2, a, na;
        bit [15:0] x88;
        bit fg, any_hit;
        bit hit [NCOMP];
        weight_vec_t w;
        longint unsigned lightest, thr;
        int min_arg;
        p = px.pixel_index % NPIX;
        base = p * NCOMP;
        x88 = {px.pixel_value, 8'd0};
        frame = (px.frame_number == 0) ? 1 : px.frame_number;
        fg = 1'b0;
        if (cfg_unimodal) begin
            if (frame <= NWARM) begin
                s = model_sum[p] + px.pixel_value;
                q = model_sq[p] + px.pixel_value * px.pixel_value;
                if (s > 12'hFFF) s = 12'hFFF;
                if (q > 20'hFFFFF) q = 20'hFFFFF;
                model_sum[p] = s[11:0];
                model_sq[p] = q[19:0];
                mean = (s * 256 + frame / 2) / frame;
                if (mean > 16'hFFFF) mean = 16'hFFFF;
                ex2 = (q * 256 + frame / 2) / frame;
                m2 = (mean * mean) >> 8;
                ex2 = (ex2 > m2) ? ex2 - m2 : 0;
                model_mean[base] = mean[15:0];
                model_var[base] = (ex2 > 64'hFFFFFF) ? 24'hFFFFFF : ex2[23:0];
            end else if (!within_sigma(x88, model_mean[base], model_var[base])) begin
                fg = 1'b1;
            end else begin
                blend_component(base, x88);
            end
        end else begin
            a = cfg_rate;
            na = 65536 - a;
            thr = 65536 - cfg_margin;
            lightest = 65536;
            min_arg = 0;
            if (frame == 1) begin
                model_mean[base] = x88;
                model_var[base] = cfg_start_var;
                model_wgt[base] = ONE_Q16;
            end
            for (int k = 0; k < NCOMP; k++) begin
                hit[k] = within_sigma(x88, model_mean[base+k], model_var[base+k]);
                if (hit[k]) blend_component(base + k, x88);
                w[k] = (na * model_wgt[base+k] + (hit[k] ? a * 65536 : 0) + 32768) >> 16;
            end
            normalize_weights(w);
            fg = 1'b1;
            for (int k = 0; k < NCOMP; k++) begin
                if (hit[k] && w[k] >= thr) begin
                    fg = 1'b0;
                    break;
                end
                if (w[k] < lightest) begin
                    lightest = w[k];
                    min_arg = k;
                end
            end
            if (fg) begin
                any_hit = cfg_selective;
                for (int k = 0; k < NCOMP; k++)
                    if (hit[k]) any_hit = 1'b1;
                if (!any_hit) begin
                    w[min_arg] = NEW_WEIGHT;
                    model_mean[base+min_arg] = x88;
                    model_var[base+min_arg] = cfg_start_var;
                    normalize_weights(w);
                end
            end
            for (int k = 0; k < NCOMP; k++)
                model_wgt[base+k] = w[k];
        end
        mask.pixel_index_out = px.pixel_index;
        mask.foreground = fg;
    endtask

    task automatic queue_pixel(pixel_in_t px);
        pending_pixels.insert(pending_pixels.size(), px);
    endtask

    // Sender: offers queued words, never drops valid before acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_out_t mask;
        if (!rst_n) begin
            pixel_valid <= 1'b0;
        end else begin
            if (pixel_valid && pixel_ready) begin
                predict_mask(pixel, mask);
                expected_masks.insert(expected_masks.size(), mask);
                pixels_sent++;
            end
            if (!pixel_valid || pixel_ready) begin
                if (pending_pixels.size() > 0 && (quiet_stretch || $urandom_range(99) >= 34)) begin
                    pixel <= pending_pixels.pop_front();
                    pixel_valid <= 1'b1;
                end else begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each word, idles at random, and holds off once for a long stretch.
    int hold_count = 0;
    bit hold_done = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        pixel_out_t want;
        if (!rst_n) begin
            result_ready <= 1'b0;
        end else begin
            if (result_valid && result_ready) begin
                results_seen++;
                if (expected_masks.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result word: index %0d fg %0d",
                                 result.pixel_index_out, result.foreground);
                end else begin
                    want = expected_masks.pop_front();
                    if (result.pixel_index_out !== want.pixel_index_out ||
                        result.foreground !== want.foreground) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: index exp %0d got %0d, fg exp %0d got %0d",
                                     want.pixel_index_out, result.pixel_index_out,
                                     want.foreground, result.foreground);
                    end
                end
            end
            if (hold_count > 0) begin
                hold_count--;
                result_ready <= 1'b0;
            end else if (!hold_done && results_seen >= 300) begin
                hold_done = 1'b1;
                hold_count = HOLD_LEN;
                result_ready <= 1'b0;
            end else begin
                result_ready <= quiet_stretch || ($urandom_range(99) >= 34);
            end
        end
    end

    // Watchdog on cycles without any accepted word; the clearing pass fits well inside.
    int stall_cycles = 0;
    always @(posedge clk)
    begin
        if ((pixel_valid && pixel_ready) || (result_valid && result_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_MAX) begin
            $display("tb_gaussian_mixture_background_model: FAIL");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge clk);
        while (pending_pixels.size() != 0 || pixel_valid || expected_masks.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_UNIMODAL:  cfg_unimodal = value[0];
            REG_RATE:      cfg_rate = value[15:0];
            REG_SIGMA:     cfg_sigma = value[11:0];
            REG_START_VAR: cfg_start_var = value[23:0];
            REG_MARGIN:    cfg_margin = value[15:0];
            REG_SELECTIVE: cfg_selective = value[0];
            default: ;
        endcase
    endtask

    function automatic pixel_in_t make_pixel(int idx, int val, int frame);
        pixel_in_t px;
        px.pixel_index = IDX_W'(idx);
        px.pixel_value = PIX_W'(val);
        px.frame_number = FRAME_W'(frame);
        return px;
    endfunction

    function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi, logic [31:0] typ);
        int r;
        r = $urandom_range(7);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return typ;
    endfunction

    initial
    begin
        int scene_idx [8];
        int scene_bg [8];
        int nframes, first_frame, val, np;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: mixture mode at reset settings, field extremes and frame zero.
        queue_pixel(make_pixel(0, 0, 1));
        queue_pixel(make_pixel(0, 0, 2));
        queue_pixel(make_pixel(0, 255, 3));
        queue_pixel(make_pixel(0, 255, 4));
        queue_pixel(make_pixel(131071, 255, 0));
        queue_pixel(make_pixel(131071, 0, 65535));
        queue_pixel(make_pixel(131071, 255, 65535));
        queue_pixel(make_pixel(5, 128, 1));
        wait_idle();

        // Directed: unimodal warmup, then a match and a miss.
        write_reg(REG_UNIMODAL, 1);
        for (int f = 1; f <= NWARM; f++)
            queue_pixel(make_pixel(7, (f % 2) ? 100 : 104, f));
        queue_pixel(make_pixel(7, 102, NWARM + 1));
        queue_pixel(make_pixel(7, 255, NWARM + 2));
        queue_pixel(make_pixel(0, 255, NWARM + 1));
        wait_idle();

        // Random scenes, each under its own register setting.
        for (int ph = 0; ph < 16; ph++) begin
            write_reg(REG_UNIMODAL, ph % 2);
            write_reg(REG_RATE, pick(0, 65535, $urandom_range(500, 20000)));
            write_reg(REG_SIGMA, pick(0, 4095, $urandom_range(256, 1200)));
            write_reg(REG_START_VAR, pick(0, 24'hFFFFFF, $urandom_range(1000, 60000)));
            write_reg(REG_MARGIN, pick(0, 65535, $urandom_range(5000, 40000)));
            write_reg(REG_SELECTIVE, $urandom_range(1));
            quiet_stretch = (ph == 6);
            np = $urandom_range(4, 8);
            for (int i = 0; i < np; i++) begin
                scene_idx[i] = $urandom_range(NPIX - 1);
                scene_bg[i] = $urandom_range(255);
            end
            nframes = $urandom_range(12, 24);
            first_frame = ($urandom_range(9) == 0) ? $urandom_range(2, 60000) : 1;
            for (int f = 0; f < nframes; f++) begin
                for (int i = 0; i < np; i++) begin
                    if ($urandom_range(9) == 0) begin
                        queue_pixel(make_pixel($urandom_range(NPIX - 1),
                            $urandom_range(255), $urandom_range(65535)));
                    end
                    if ($urandom_range(7) == 0)
                        val = $urandom_range(255);
                    else
                        val = scene_bg[i] + $urandom_range(8) - 4;
                    if (val < 0) val = 0;
                    if (val > 255) val = 255;
                    queue_pixel(make_pixel(scene_idx[i], val, first_frame + f));
                end
            end
            wait_idle();
        end
        quiet_stretch = 1'b0;

        repeat (200) @(posedge clk);
        if (errors == 0 && expected_masks.size() == 0)
            $display("tb_gaussian_mixture_background_model: PASS");
        else
            $display("tb_gaussian_mixture_background_model: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/gmbm_pkg.sv
rtl/gmbm_mac.sv
rtl/gmbm_div.sv
rtl/gmbm_cfg.sv
rtl/gmbm_core.sv
rtl/gaussian_mixture_background_model.sv
sim/tb_gaussian_mixture_background_model.sv
